@@ rtl/skf_pkg.sv @@
// ----------------------------------------------------------------------------
// skf_pkg
// shared types, widths and constants of the scalar kalman filter
// ----------------------------------------------------------------------------
package skf_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GAIN_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = GAIN_BITS + 1;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int DENOM_W    = DATA_W + 1;
    localparam int REM_W      = DATA_W + 2;
    localparam int EPROD_W    = DIFF_W + GAIN_W + 1;
    localparam int CPROD_W    = DATA_W + GAIN_W;
    localparam int EST_W      = DATA_W + 4;
    localparam int CNT_W      = 5;
    localparam int OUT_BITS   = 2 * DATA_W + GAIN_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // covariance after reset: 1000.0 in fixed point, saturated to 32 bits
    localparam logic [63:0] COV_RESET_WIDE = 64'd1000 << FRAC_BITS;
    localparam logic [DATA_W-1:0] COV_RESET =
        (COV_RESET_WIDE > 64'hFFFF_FFFF) ? {DATA_W{1'b1}} : COV_RESET_WIDE[DATA_W-1:0];

    localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd6554;
    localparam logic [DATA_W-1:0] MEASURE_NOISE_RESET = 32'd32768;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;
    localparam logic [CNT_W-1:0]  DIV_STEPS_LAST = CNT_W'(GAIN_BITS);

    // configuration register indexes
    localparam logic REG_PROCESS_NOISE = 1'b0;
    localparam logic REG_MEASURE_NOISE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MULT,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic div_step;
        logic mult;
        logic finish;
    } skf_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } skf_status_t;

endpackage

@@ rtl/skf_ctrl.sv @@
// ----------------------------------------------------------------------------
// skf_ctrl
// sequencer for one filter step: prepare, divide, multiply, write back
// ----------------------------------------------------------------------------
module skf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  skf_pkg::skf_status_t status,
    output skf_pkg::skf_cmd_t   cmd
);
    import skf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_MULT;
                end
            end
            ST_MULT:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_MULT:
            begin
                cmd.mult = 1'b1;
            end
            ST_WRITE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ rtl/skf_datapath.sv @@
// ----------------------------------------------------------------------------
// skf_datapath
// filter state, config registers, restoring gain divider, products, output
// ----------------------------------------------------------------------------
module skf_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]    cfg_data,
    input  logic [skf_pkg::DATA_W-1:0]    sample,
    input  skf_pkg::skf_cmd_t             cmd,
    output skf_pkg::skf_status_t          status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [skf_pkg::OUT_DATA_W-1:0] m_tdata
);
    import skf_pkg::*;

    logic [DATA_W-1:0]  process_noise_reg;
    logic [DATA_W-1:0]  measure_noise_reg;
    logic [DATA_W-1:0]  est_reg;
    logic [DATA_W-1:0]  cov_reg;

    logic [DATA_W-1:0]  sample_reg;
    logic [DATA_W-1:0]  pred_reg;
    logic [DATA_W-1:0]  pmid_reg;
    logic [DENOM_W-1:0] denom_reg;
    logic               denom_zero_reg;
    logic [DIFF_W-1:0]  diff_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [GAIN_W-1:0]  quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [EPROD_W-1:0] eprod_reg;
    logic [CPROD_W-1:0] cprod_reg;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  out_est_reg;
    logic [DATA_W-1:0]  out_pred_reg;
    logic [GAIN_W-1:0]  out_gain_reg;

    logic [DATA_W:0]    pmid_sum;
    logic [DATA_W-1:0]  pmid_next;
    logic               div_ge;
    logic [REM_W-1:0]   div_sub;
    logic [GAIN_W-1:0]  gain_next;
    logic [EPROD_W-1:0] eprod_next;
    logic [CPROD_W-1:0] cprod_next;
    logic [EPROD_W-1:0] eprod_round;
    logic [EST_W-1:0]   est_delta;
    logic [EST_W-1:0]   est_wide;
    logic [DATA_W-1:0]  est_next;
    logic [CPROD_W-1:0] cprod_round;
    logic [DATA_W:0]    cov_wide;
    logic [DATA_W-1:0]  cov_next;

    // predicted covariance, saturating
    assign pmid_sum  = {1'b0, cov_reg} + {1'b0, process_noise_reg};
    assign pmid_next = pmid_sum[DATA_W] ? {DATA_W{1'b1}} : pmid_sum[DATA_W-1:0];

    // one restoring divide step per cycle, msb of the gain first
    assign div_ge  = rem_reg >= {1'b0, denom_reg};
    assign div_sub = div_ge ? (rem_reg - {1'b0, denom_reg}) : rem_reg;

    // zero divisor gives zero gain
    assign gain_next = denom_zero_reg ? '0 : quot_reg;

    assign eprod_next = EPROD_W'($signed(diff_reg) * $signed({1'b0, gain_next}));
    assign cprod_next = CPROD_W'(pmid_reg * (GAIN_ONE - gain_next));

    // estimate: prediction plus rounded correction, clamped to 32 bits
    assign eprod_round = eprod_reg + EPROD_W'(1 << (GAIN_BITS - 1));
    assign est_delta   = EST_W'($signed(eprod_round) >>> GAIN_BITS);
    assign est_wide    = {{(EST_W-DATA_W){pred_reg[DATA_W-1]}}, pred_reg} + est_delta;

    always_comb
    begin
        if ($signed(est_wide) > $signed(EST_W'({1'b0, {(DATA_W-1){1'b1}}})))
        begin
            est_next = {1'b0, {(DATA_W-1){1'b1}}};
        end
        else if ($signed(est_wide) < $signed({{(EST_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}}))
        begin
            est_next = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            est_next = est_wide[DATA_W-1:0];
        end
    end

    // covariance shrinks by one minus gain, rounded, saturating
    assign cprod_round = cprod_reg + CPROD_W'(1 << (GAIN_BITS - 1));
    assign cov_wide    = cprod_round[GAIN_BITS +: DATA_W + 1];
    assign cov_next    = cov_wide[DATA_W] ? {DATA_W{1'b1}} : cov_wide[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg <= PROCESS_NOISE_RESET;
            measure_noise_reg <= MEASURE_NOISE_RESET;
            est_reg           <= '0;
            cov_reg           <= COV_RESET;
            out_valid_reg     <= 1'b0;
            cnt_reg           <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PROCESS_NOISE: process_noise_reg <= cfg_data;
                    REG_MEASURE_NOISE: measure_noise_reg <= cfg_data;
                    default:           process_noise_reg <= process_noise_reg;
                endcase
            end
            if (cmd.prep)
            begin
                cnt_reg <= DIV_STEPS_LAST;
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.finish)
            begin
                est_reg       <= est_next;
                cov_reg       <= cov_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
            pred_reg   <= est_reg;
            pmid_reg   <= pmid_next;
        end
        if (cmd.prep)
        begin
            denom_reg      <= {1'b0, pmid_reg} + {1'b0, measure_noise_reg};
            denom_zero_reg <= (pmid_reg == '0) && (measure_noise_reg == '0);
            rem_reg        <= {2'b00, pmid_reg};
            quot_reg       <= '0;
            diff_reg       <= {sample_reg[DATA_W-1], sample_reg} - {pred_reg[DATA_W-1], pred_reg};
        end
        if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[GAIN_W-2:0], div_ge};
            rem_reg  <= {div_sub[REM_W-2:0], 1'b0};
        end
        if (cmd.mult)
        begin
            gain_reg  <= gain_next;
            eprod_reg <= eprod_next;
        end
        if (cmd.mult)
        begin
            cprod_reg <= cprod_next;
        end
        if (cmd.finish)
        begin
            out_est_reg  <= est_next;
            out_pred_reg <= pred_reg;
            out_gain_reg <= gain_reg;
        end
    end

    // cprod uses the gain registered in the same cycle, so take it from quotient path
    assign status.div_last = (cnt_reg == '0);
    assign status.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_BITS){1'b0}}, out_gain_reg, out_pred_reg, out_est_reg};

endmodule

@@ rtl/scalar_kalman_filter_top.sv @@
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top
// one-dimensional kalman filter on signed q16.16 samples
// ----------------------------------------------------------------------------
// Each sample transfer runs one predict/update step: the covariance is
// grown by the process noise (saturating), the gain p/(p+r) is formed in
// Q1.16, the estimate moves toward the sample by the gain and the covariance
// shrinks by one minus the gain. One result transfer follows every sample,
// carrying the new estimate, the estimate it started from and the gain.
// Each item passes through a prepare step, the bit-serial restoring
// divider that forms the gain one bit a cycle, a multiply step and a
// write-back step, which waits while the previous result is still held in
// the output register; the next sample is taken in the idle state. One
// sample is worked at a time, and a new sample is taken while the previous
// result still waits in the output register. Configuration writes take
// effect at once and belong in idle periods; reset sets process noise 6554,
// measurement noise 32768, estimate zero and covariance 1000.0.
// ----------------------------------------------------------------------------
module scalar_kalman_filter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [skf_pkg::DATA_W-1:0]         cfg_data,
    // sample input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [skf_pkg::DATA_W-1:0]         s_tdata,   // [31:0] sample
    // filter result
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [skf_pkg::OUT_DATA_W-1:0]     m_tdata    // [31:0] estimate,
                                                          // [63:32] prediction,
                                                          // [80:64] gain, rest zero
);
    import skf_pkg::*;

    skf_cmd_t    cmd;
    skf_status_t status;

    // step sequencer
    skf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic, filter state and output register
    skf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

@@ dv/tb_scalar_kalman_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter_top
// self-checking bench for the scalar kalman filter
// ----------------------------------------------------------------------------
// Samples are streamed into the filter while a bit-accurate estimate tracker
// computes the estimate, prediction and gain that each one should produce.
// Results are matched in order. A directed part hits the sample extremes,
// covariance saturation and zero measurement noise. Random phases follow
// under many noise settings and three sender/receiver idle mixes.
// ----------------------------------------------------------------------------

typedef struct {
    logic [skf_pkg::DATA_W-1:0] estimate;
    logic [skf_pkg::DATA_W-1:0] prediction;
    logic [skf_pkg::GAIN_W-1:0] gain;
} kf_result_t;

class kf_estimate_board;
    logic [31:0]  proc_noise;
    logic [31:0]  meas_noise;
    logic [31:0]  est_q;
    logic [31:0]  cov_q;
    kf_result_t   awaited[$];
    int unsigned  errors;
    int unsigned  checked;

    function new();
        bit [63:0] c;
        c          = 64'd1000 << skf_pkg::FRAC_BITS;
        proc_noise = 32'd6554;
        meas_noise = 32'd32768;
        est_q      = '0;
        cov_q      = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
        errors     = 0;
        checked    = 0;
    endfunction

    function void set_noise(logic [31:0] q, logic [31:0] r);
        proc_noise = q;
        meas_noise = r;
    endfunction

    // one predict/update step on an accepted sample
    function void take_sample(logic [31:0] raw);
        longint     smp;
        longint     prv;
        longint     step;
        longint     est;
        bit [63:0]  pmid;
        bit [63:0]  denom;
        bit [63:0]  gn;
        bit [63:0]  cv;
        kf_result_t want;
        smp   = longint'($signed(raw));
        prv   = longint'($signed(est_q));
        pmid  = 64'(cov_q) + 64'(proc_noise);
        if (pmid > 64'hFFFF_FFFF)
            pmid = 64'hFFFF_FFFF;
        denom = pmid + 64'(meas_noise);
        gn    = (denom == 0) ? 64'd0 : (pmid << 16) / denom;
        step  = (smp - prv) * longint'(gn) + 64'sd32768;
        est   = prv + (step >>> 16);
        if (est > 64'sd2147483647)
            est = 64'sd2147483647;
        if (est < -64'sd2147483648)
            est = -64'sd2147483648;
        cv = (pmid * (64'd65536 - gn) + 64'd32768) >> 16;
        if (cv > 64'hFFFF_FFFF)
            cv = 64'hFFFF_FFFF;
        want.estimate   = est[31:0];
        want.prediction = est_q;
        want.gain       = gn[16:0];
        awaited.push_back(want);
        est_q = est[31:0];
        cov_q = cv[31:0];
    endfunction

    function void check_result(logic [skf_pkg::OUT_DATA_W-1:0] td);
        kf_result_t want;
        if (awaited.size() == 0) begin
            $display("%0t: result %h arrived with nothing pending", $time, td);
            errors++;
            return;
        end
        want = awaited.pop_front();
        checked++;
        if (td[31:0] !== want.estimate) begin
            $display("%0t: estimate mismatch, expected %h actual %h",
                     $time, want.estimate, td[31:0]);
            errors++;
        end
        if (td[63:32] !== want.prediction) begin
            $display("%0t: prediction mismatch, expected %h actual %h",
                     $time, want.prediction, td[63:32]);
            errors++;
        end
        if (td[80:64] !== want.gain) begin
            $display("%0t: gain mismatch, expected %h actual %h",
                     $time, want.gain, td[80:64]);
            errors++;
        end
        if (td[skf_pkg::OUT_DATA_W-1:81] !== '0) begin
            $display("%0t: padding mismatch, expected %h actual %h",
                     $time, 7'h0, td[skf_pkg::OUT_DATA_W-1:81]);
            errors++;
        end
    endfunction
endclass

module tb_scalar_kalman_filter_top;
    import skf_pkg::*;

    localparam int LATENCY     = 21;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_ITEMS = 94;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = REG_PROCESS_NOISE;
    logic [DATA_W-1:0]     cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    kf_estimate_board      kf = new();
    int unsigned           send_idle_pct = 14;
    int unsigned           recv_idle_pct = 64;
    int unsigned           n_sent;
    int unsigned           n_settings;
    int unsigned           cycle_count;
    logic [31:0]           track_base;

    scalar_kalman_filter_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    // receiver: random back-pressure, checked at the rising edge
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            kf.check_result(m_tdata);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, kf.awaited.size());
            $display("tb_scalar_kalman_filter_top: FAIL");
            $finish;
        end
    end

    // one sample transfer; entered and left at a falling edge with valid
    // left as it is so a back-to-back item keeps it high
    task automatic send_sample(input logic [31:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        kf.take_sample(value);
        n_sent++;
        @(negedge clk);
    endtask

    // stop sending and wait for every pending result to come back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (kf.awaited.size() != 0)
            @(negedge clk);
    endtask

    // both noise registers, back to back; filter must be idle
    task automatic write_noise(input logic [31:0] q, input logic [31:0] r);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROCESS_NOISE;
        cfg_data  <= q;
        @(negedge clk);
        cfg_index <= REG_MEASURE_NOISE;
        cfg_data  <= r;
        @(negedge clk);
        cfg_we    <= 1'b0;
        kf.set_noise(q, r);
        n_settings++;
    endtask

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(1, 255);
            3: return $urandom_range(256, 32'h0004_0000);
            4: return $urandom;
            default: return 32'd1;
        endcase
    endfunction

    // mostly a noisy tracked signal, with jumps, extremes and raw noise
    function automatic logic [31:0] next_sample();
        int unsigned sel;
        int          delta;
        sel   = $urandom_range(99);
        delta = int'($urandom_range(0, 524288)) - 262144;
        if (sel < 55)
        begin
            track_base = track_base + (delta >>> 4);
            return track_base + delta;
        end
        else if (sel < 70)
            return $urandom;
        else if (sel < 80)
        begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        else
        begin
            track_base = $urandom;
            return track_base;
        end
    endfunction

    initial
    begin
        logic [31:0] dir_reset [] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001,
                                      32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000,
                                      32'h5555_5555, 32'hAAAA_AAAA};
        logic [31:0] dir_three [] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678};
        logic [31:0] q;
        logic [31:0] r;
        int          pressure_at;

        track_base = $urandom;
        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset noise values, extreme samples while gain is near one
        send_idle_pct = 14;
        recv_idle_pct = 64;
        foreach (dir_reset[i])
            send_sample(dir_reset[i]);
        drain();

        // zero measurement noise: estimate jumps to the sample, covariance to 0
        write_noise(32'd6554, 32'd0);
        foreach (dir_three[i])
            send_sample(dir_three[i]);
        drain();

        // both noises zero with covariance already 0: divide by zero, gain 0
        write_noise(32'd0, 32'd0);
        foreach (dir_three[i])
            send_sample(dir_three[i]);
        drain();

        // full-scale process noise: covariance saturates
        write_noise(32'hFFFF_FFFF, 32'd1);
        foreach (dir_three[i])
            send_sample(dir_three[i]);
        drain();

        write_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        foreach (dir_three[i])
            send_sample(~dir_three[i]);
        drain();

        // random phases: sender-light, receiver-light, then no idling
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph < RAND_PHASES / 3)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 64;
            end
            else if (ph < 2 * RAND_PHASES / 3)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            q = pick_noise();
            r = pick_noise();
            write_noise(q, r);
            pressure_at = (ph % 3 == 1) ? $urandom_range(10, PHASE_ITEMS - 10) : -1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // hold the sender off until the filter has emptied
                if (i == pressure_at)
                    drain();
                send_sample(next_sample());
            end
            drain();
        end

        repeat (LATENCY + 10)
            @(negedge clk);

        $display("covered %0d samples across %0d noise settings plus reset values",
                 n_sent, n_settings);
        $display("%0d results checked under three idle mixes, %0d mismatches",
                 kf.checked, kf.errors);
        if (kf.errors == 0 && kf.awaited.size() == 0)
            $display("tb_scalar_kalman_filter_top: PASS");
        else
            $display("tb_scalar_kalman_filter_top: FAIL");
        $finish;
    end

endmodule
